// ===== hw/rtl/upd_pkg.sv =====
// Shared constants and character helpers for the URL percent decoder.
`default_nettype none
package upd_pkg;

  localparam int unsigned HOLD_DEPTH = 5;
  localparam int unsigned MAX_RES    = HOLD_DEPTH + 1;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_SPACE = 8'h20;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) ||
           (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  // Nibble value of a hex digit; letters carry bit 6, so add nine to the low bits
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [3:0] v;
    v = c[6] ? (c[3:0] + 4'd9) : c[3:0];
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/url_percent_decoder_unit.sv =====
// URL percent decoder: input register, single-pass decode, result buffer.
// A request passes through the input register and is decoded into the result buffer, which offers its first result.
// Throughput: one request per cycle while each yields at most one result and out_stall is low; a
// request yielding n results (n up to six) holds the result buffer until all n have been taken.
// Reset: synchronous active-low rst_n clears the escape state, input and result buffers.
`default_nettype none
module url_percent_decoder_unit
  import upd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_has_byte,
  output logic            out_last
);

  // input register
  logic       inq_valid_r;
  logic [7:0] inq_byte_r;
  logic       inq_last_r;

  // escape state
  logic [2:0] phase_r, phase_nxt;
  logic       wide_r, wide_nxt;
  logic [7:0] held_r [HOLD_DEPTH];

  // result buffer
  logic [7:0] ob_byte_r [MAX_RES];
  logic [7:0] ob_byte_nxt [MAX_RES];
  logic [2:0] ob_cnt_r, ob_cnt_nxt;
  logic [2:0] ob_idx_r;
  logic       ob_has_r, ob_has_nxt;
  logic       ob_last_r;

  logic       ob_final;
  logic       buf_free;
  logic       consume;

  // decode signals
  logic       hex_ok;
  logic [3:0] hv;
  logic       broken;
  logic       hold_en;
  logic [2:0] hold_idx;
  logic       x_en;
  logic [7:0] x_val;
  logic [2:0] flush_n;
  logic [2:0] res_n;
  logic       marker;

  assign out_valid    = (ob_idx_r != ob_cnt_r);
  assign ob_final     = (ob_idx_r == (ob_cnt_r - 3'd1));
  assign buf_free     = !out_valid || (!out_stall && ob_final);
  assign consume      = inq_valid_r && buf_free;
  assign in_stall     = inq_valid_r && !buf_free;

  assign out_byte     = ob_byte_r[ob_idx_r];
  assign out_has_byte = ob_has_r;
  assign out_last     = ob_last_r && ob_final;

  always_comb begin
    hex_ok    = is_hex(inq_byte_r);
    hv        = hex_nibble(inq_byte_r);
    broken    = 1'b0;
    hold_en   = 1'b0;
    hold_idx  = phase_r;
    x_en      = 1'b0;
    x_val     = (inq_byte_r == CH_PLUS) ? CH_SPACE : inq_byte_r;
    flush_n   = 3'd0;
    phase_nxt = phase_r;
    wide_nxt  = wide_r;

    priority if (phase_r == 3'd0) begin
      if (inq_byte_r == CH_PCT) begin
        hold_en  = 1'b1;
        wide_nxt = 1'b0;
      end else begin
        x_en = 1'b1;
      end
    end else if (phase_r == 3'd1) begin
      if (hex_ok) begin
        hold_en  = 1'b1;
        wide_nxt = 1'b0;
      end else if (inq_byte_r == CH_U) begin
        hold_en  = 1'b1;
        wide_nxt = 1'b1;
      end else begin
        broken = 1'b1;
      end
    end else if (!wide_r) begin
      if (hex_ok) begin
        x_en      = 1'b1;
        x_val     = {hex_nibble(held_r[1]), hv};
        phase_nxt = 3'd0;
      end else begin
        broken = 1'b1;
      end
    end else begin
      if (hex_ok) begin
        if (phase_r >= 3'(HOLD_DEPTH)) begin
          // wide escape complete: drop it
          phase_nxt = 3'd0;
          wide_nxt  = 1'b0;
        end else begin
          hold_en = 1'b1;
        end
      end else begin
        broken = 1'b1;
      end
    end

    if (hold_en) begin
      phase_nxt = phase_r + 3'd1;
    end

    // broken escape: flush held characters, then decode the byte afresh
    if (broken) begin
      flush_n  = phase_r;
      wide_nxt = 1'b0;
      hold_idx = 3'd0;
      if (inq_byte_r == CH_PCT) begin
        hold_en   = 1'b1;
        phase_nxt = 3'd1;
      end else begin
        x_en      = 1'b1;
        phase_nxt = 3'd0;
      end
    end

    // end of string: whatever would be held goes out literally
    if (inq_last_r) begin
      if (hold_en) begin
        flush_n = phase_r;
        x_en    = 1'b1;
        x_val   = inq_byte_r;
        hold_en = 1'b0;
      end
      phase_nxt = 3'd0;
      wide_nxt  = 1'b0;
    end

    res_n  = flush_n + {2'b00, x_en};
    marker = inq_last_r && (res_n == 3'd0);

    for (int i = 0; i < HOLD_DEPTH; i++) begin
      ob_byte_nxt[i] = (3'(i) < flush_n) ? held_r[i] : x_val;
    end
    ob_byte_nxt[MAX_RES-1] = x_val;
    if (marker) begin
      ob_byte_nxt[0] = 8'h00;
    end
    ob_cnt_nxt = marker ? 3'd1 : res_n;
    ob_has_nxt = !marker;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
      phase_r     <= 3'd0;
      wide_r      <= 1'b0;
      ob_cnt_r    <= 3'd0;
      ob_idx_r    <= 3'd0;
    end else begin
      if (!in_stall) begin
        inq_valid_r <= in_valid;
      end
      if (consume) begin
        phase_r  <= phase_nxt;
        wide_r   <= wide_nxt;
        ob_cnt_r <= ob_cnt_nxt;
        ob_idx_r <= 3'd0;
      end else if (out_valid && !out_stall) begin
        ob_idx_r <= ob_idx_r + 3'd1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      inq_byte_r <= in_byte;
      inq_last_r <= in_last;
    end
    if (consume) begin
      if (hold_en) begin
        held_r[hold_idx] <= inq_byte_r;
      end
      for (int i = 0; i < MAX_RES; i++) begin
        ob_byte_r[i] <= ob_byte_nxt[i];
      end
      ob_has_r  <= ob_has_nxt;
      ob_last_r <= inq_last_r;
    end
  end

`ifndef SYNTHESIS
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= 3'(HOLD_DEPTH))
    else $error("held count beyond hold depth");

  a_wide_needs_u: assert property (@(posedge clk) disable iff (!rst_n)
    wide_r |-> (phase_r >= 3'd2))
    else $error("wide escape flagged without a held u");

  a_plain_short: assert property (@(posedge clk) disable iff (!rst_n)
    !wide_r |-> (phase_r <= 3'd2))
    else $error("plain escape holds too many characters");

  a_marker_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_byte) |-> out_last)
    else $error("bare end marker not flagged last");

  a_consume_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (consume && inq_last_r) |=> (phase_r == 3'd0) && !wide_r)
    else $error("escape state survives end of string");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the URL percent decoder: directed table, then random strings.
`timescale 1ns / 1ps
module tb_top;
  import upd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 250000;
  localparam int unsigned RANDOM_ITEMS = 360;
  localparam int unsigned QUIET_TAIL   = 50;
  localparam int unsigned DRAIN_CYCLES = 10;

  typedef struct packed {
    logic [7:0] ch;
    logic       has;
    logic       last;
  } decoded_char_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } enc_char_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       typed;
    logic [7:0] want_ch;
    logic       want_has;
    logic       want_last;
  } dir_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_has_byte;
  logic       out_last;

  url_percent_decoder_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_has_byte (out_has_byte),
    .out_last     (out_last)
  );

  // Escape tracker state
  logic [2:0] esc_count;
  logic       esc_wide;
  logic [7:0] esc_held [HOLD_DEPTH];

  decoded_char_t decoded_q [$];
  decoded_char_t step_chars [$];
  enc_char_t     enc_q [$];
  dir_row_t      dir_rows [26];

  int unsigned cycles;
  int unsigned err_count;
  int unsigned stall_left;
  bit          quiet;

  initial begin
    clk = 1'b0;
  end
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int hex_digit_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - 48;
    if (c >= "A" && c <= "F") return int'(c) - 55;
    if (c >= "a" && c <= "f") return int'(c) - 87;
    return -1;
  endfunction

  function automatic logic [7:0] rand_hex_digit();
    int unsigned k;
    k = $urandom_range(0, 21);
    if (k < 10) return 8'(8'h30 + k);
    if (k < 16) return 8'(8'h41 + k - 10);
    return 8'(8'h61 + k - 16);
  endfunction

  task automatic emit_char(input logic [7:0] c, input logic has);
    decoded_char_t r;
    r.ch   = has ? c : 8'h00;
    r.has  = has;
    r.last = 1'b0;
    step_chars.push_back(r);
  endtask

  task automatic hold_char(input logic [7:0] c);
    esc_held[esc_count] = c;
    esc_count = esc_count + 3'd1;
  endtask

  task automatic flush_escape();
    for (int i = 0; i < esc_count && i < HOLD_DEPTH; i++) emit_char(esc_held[i], 1'b1);
    esc_count = 3'd0;
    esc_wide  = 1'b0;
  endtask

  task automatic decode_plain(input logic [7:0] c);
    if (c == CH_PLUS) begin
      emit_char(CH_SPACE, 1'b1);
    end else if (c == CH_PCT) begin
      esc_count = 3'd0;
      esc_wide  = 1'b0;
      hold_char(c);
    end else begin
      emit_char(c, 1'b1);
    end
  endtask

  // Work out the decoded characters caused by one request into step_chars
  task automatic predict_decode(input logic [7:0] c, input logic last);
    int  hv;
    int  hi;
    bit  broken;
    hv     = hex_digit_value(c);
    broken = 1'b0;
    step_chars.delete();
    if (esc_count == 3'd0) begin
      decode_plain(c);
    end else if (esc_count == 3'd1) begin
      if (hv >= 0) begin
        esc_wide = 1'b0;
        hold_char(c);
      end else if (c == CH_U) begin
        esc_wide = 1'b1;
        hold_char(c);
      end else begin
        broken = 1'b1;
      end
    end else if (!esc_wide) begin
      if (hv >= 0) begin
        hi = hex_digit_value(esc_held[1]);
        if (hi < 0) hi = 0;
        esc_count = 3'd0;
        emit_char(8'((hi * 16 + hv) & 255), 1'b1);
      end else begin
        broken = 1'b1;
      end
    end else begin
      if (hv >= 0) begin
        // Drop a completed wide escape
        if (esc_count >= HOLD_DEPTH) begin
          esc_count = 3'd0;
          esc_wide  = 1'b0;
        end else begin
          hold_char(c);
        end
      end else begin
        broken = 1'b1;
      end
    end
    if (broken) begin
      flush_escape();
      decode_plain(c);
    end
    if (last) begin
      flush_escape();
      if (step_chars.size() == 0) emit_char(8'h00, 1'b0);
      step_chars[step_chars.size() - 1].last = 1'b1;
    end
  endtask

  task automatic report_mismatch(input string what);
    if (err_count < 10) $display("[%0t] mismatch: %s", $realtime, what);
    err_count++;
  endtask

  // Drive one request from a falling edge; return at the falling edge after acceptance
  task automatic send_request(input dir_row_t row);
    decoded_char_t w;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= row.ch;
    in_last  <= row.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_decode(row.ch, row.last);
    if (row.typed) begin
      w.ch   = row.want_ch;
      w.has  = row.want_has;
      w.last = row.want_last;
      decoded_q.push_back(w);
    end else begin
      foreach (step_chars[i]) decoded_q.push_back(step_chars[i]);
    end
    @(negedge clk);
  endtask

  task automatic gen_random_strings();
    int unsigned n_tok;
    int unsigned kind;
    int unsigned m;
    enc_char_t   e;
    e.last = 1'b0;
    while (enc_q.size() < RANDOM_ITEMS) begin
      n_tok = $urandom_range(1, 8);
      for (int t = 0; t < n_tok; t++) begin
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
          e.ch = 8'($urandom_range(0, 255)); enc_q.push_back(e);
        end else if (kind < 40) begin
          e.ch = CH_PLUS; enc_q.push_back(e);
        end else if (kind < 60) begin
          e.ch = CH_PCT; enc_q.push_back(e);
          repeat (2) begin e.ch = rand_hex_digit(); enc_q.push_back(e); end
        end else if (kind < 75) begin
          e.ch = CH_PCT; enc_q.push_back(e);
          e.ch = CH_U;   enc_q.push_back(e);
          repeat (4) begin e.ch = rand_hex_digit(); enc_q.push_back(e); end
        end else if (kind < 92) begin
          // Start an escape, then follow it with an arbitrary byte, which may break it
          e.ch = CH_PCT; enc_q.push_back(e);
          m = $urandom_range(0, 2);
          if (m == 1) begin
            e.ch = rand_hex_digit(); enc_q.push_back(e);
          end else if (m == 2) begin
            e.ch = CH_U; enc_q.push_back(e);
            repeat ($urandom_range(0, 3)) begin e.ch = rand_hex_digit(); enc_q.push_back(e); end
          end
          e.ch = 8'($urandom_range(0, 255)); enc_q.push_back(e);
        end else begin
          e.ch = CH_PCT; enc_q.push_back(e);
        end
      end
      enc_q[enc_q.size() - 1].last = 1'b1;
    end
  endtask

  always @(negedge clk) begin
    if (rst_n && !quiet && stall_left == 0 && $urandom_range(0, 7) == 0)
      stall_left = $urandom_range(1, 14);
    if (stall_left > 0 && !quiet) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    decoded_char_t got;
    decoded_char_t want;
    got.ch   = out_byte;
    got.has  = out_has_byte;
    got.last = out_last;
    if (rst_n && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte=%02h has=%0b last=%0b",
                                  got.ch, got.has, got.last));
      end else begin
        want = decoded_q.pop_front();
        if (got.ch != want.ch)
          report_mismatch($sformatf("out_byte exp %02h got %02h", want.ch, got.ch));
        if (got.has != want.has)
          report_mismatch($sformatf("out_has_byte exp %0b got %0b", want.has, got.has));
        if (got.last != want.last)
          report_mismatch($sformatf("out_last exp %0b got %0b", want.last, got.last));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    dir_row_t r;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_byte    = 8'h00;
    in_last    = 1'b0;
    out_stall  = 1'b0;
    cycles     = 0;
    err_count  = 0;
    stall_left = 0;
    quiet      = 1'b0;
    esc_count  = 3'd0;
    esc_wide   = 1'b0;
    foreach (esc_held[i]) esc_held[i] = 8'h00;

    dir_rows = '{
      '{CH_PLUS, 1'b0, 1'b1, CH_SPACE, 1'b1, 1'b0},
      '{8'h00,   1'b0, 1'b1, 8'h00,    1'b1, 1'b0},   // zero byte is ordinary
      '{8'hFF,   1'b0, 1'b1, 8'hFF,    1'b1, 1'b0},
      '{CH_PCT,  1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
      '{"4",     1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
      '{"1",     1'b0, 1'b1, 8'h41,    1'b1, 1'b0},
      '{CH_PCT,  1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
      '{"f",     1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
      '{"F",     1'b0, 1'b1, 8'hFF,    1'b1, 1'b0},
      // broken wide escape with the hold full: six results
      '{CH_PCT,  1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
      '{CH_U,    1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
      '{"1",     1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
      '{"2",     1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
      '{"3",     1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
      '{"z",     1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
      '{CH_PCT,  1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
      '{CH_PCT,  1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
      '{"7",     1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
      '{"x",     1'b1, 1'b0, 8'h00,    1'b0, 1'b0},
      '{CH_PCT,  1'b1, 1'b1, CH_PCT,   1'b1, 1'b1},
      // completed wide escape on the last byte leaves a bare end marker
      '{CH_PCT,  1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
      '{CH_U,    1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
      '{"a",     1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
      '{"B",     1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
      '{"c",     1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
      '{"9",     1'b1, 1'b1, 8'h00,    1'b0, 1'b1}
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) send_request(dir_rows[i]);

    gen_random_strings();
    r.typed     = 1'b0;
    r.want_ch   = 8'h00;
    r.want_has  = 1'b0;
    r.want_last = 1'b0;
    foreach (enc_q[i]) begin
      quiet  = (i + QUIET_TAIL >= enc_q.size());
      r.ch   = enc_q[i].ch;
      r.last = enc_q[i].last;
      send_request(r);
    end
    in_valid <= 1'b0;

    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
